// ===== design/qbf_pkg.sv =====
// Shared types and constants for the QUBO exhaustive minimum search.
// Used by the top level and the energy unit; depends on nothing else.
`timescale 1ns / 1ps

package qbf_pkg;

  localparam int CFG_W    = 5;
  localparam int ENERGY_W = 25;
  localparam int PATT_W   = 16;
  localparam int END_W    = 17;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 25'sh0FFFFFF;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 25'sh1000000;

  typedef struct packed {
    logic                    operation;
    logic [3:0]              row;
    logic [3:0]              col;
    logic signed [15:0]      weight;
    logic [PATT_W-1:0]       range_begin;
    logic [END_W-1:0]        range_end;
  } in_item_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] min_energy;
    logic [PATT_W-1:0]          best_pattern;
    logic                       range_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPORT
  } state_t;

endpackage

// ===== design/qubo_brute_force_min_search.sv =====
// Top level of the QUBO exhaustive minimum search: command port, pattern
// sequencer, best-energy tracking and weight RAM. Depends on qbf_pkg,
// qbf_ram and qbf_energy_unit.
// Load: busy stays low. Empty search: result strobe in the cycle after transfer.
// Search: the energy unit walks the N*N weights of each pattern (one weight RAM read per
// cycle); busy high throughout.
// Results strobe for one cycle and cannot be stalled. Reset (synchronous, rst_n low)
// sets N to 16 and idles the sequencer; weights are undefined until loaded.
`timescale 1ns / 1ps

module qubo_brute_force_min_search #(
  parameter int MAX_BITS    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  qbf_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output qbf_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [qbf_pkg::CFG_W-1:0]  cfg_wdata
);

  import qbf_pkg::*;

  localparam int IDX_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int DEPTH  = MAX_BITS * MAX_BITS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = WEIGHT_BITS + 2 * $clog2(MAX_BITS) + 1;
  localparam int CMP_W  = (ACC_W > ENERGY_W) ? ACC_W : ENERGY_W;
  localparam int LIM_W  = ((MAX_BITS + 1) > END_W) ? (MAX_BITS + 1) : END_W;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_bits_r;
  logic [END_W-1:0]  patt_r, patt_nxt;
  logic [END_W-1:0]  end_r, end_nxt;
  logic              first_r, first_nxt;
  logic              go_r, go_nxt;
  logic [IDX_W-1:0]  n_last_r, n_last_nxt;
  logic signed [ACC_W-1:0] best_e_r, best_e_nxt;
  logic [PATT_W-1:0] best_p_r, best_p_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [WEIGHT_BITS-1:0] ram_rd_data;
  logic              eu_done;
  logic signed [ACC_W-1:0] eu_energy;
  logic [CFG_W-1:0]  n_act;
  logic [LIM_W-1:0]  lim;
  logic [END_W-1:0]  end_c;
  logic signed [CMP_W-1:0] e_ext;
  logic signed [CMP_W-1:0] e_sat;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_we = accept && (in_data.operation == OP_LOAD) &&
                  ({1'b0, in_data.row} < CFG_W'(MAX_BITS)) &&
                  ({1'b0, in_data.col} < CFG_W'(MAX_BITS));
  assign ram_wr_addr = ADDR_W'(ADDR_W'(in_data.row) * ADDR_W'(MAX_BITS) +
                               ADDR_W'(in_data.col));

  always_comb begin
    if (cfg_bits_r == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_bits_r > CFG_W'(MAX_BITS)) begin
      n_act = CFG_W'(MAX_BITS);
    end else begin
      n_act = cfg_bits_r;
    end
  end

  assign lim   = LIM_W'(1) << n_act;
  assign end_c = (LIM_W'(in_data.range_end) > lim) ? END_W'(lim) : in_data.range_end;

  assign e_ext = CMP_W'(best_e_r);
  always_comb begin
    if (e_ext > CMP_W'(ENERGY_MAX)) begin
      e_sat = CMP_W'(ENERGY_MAX);
    end else if (e_ext < CMP_W'(ENERGY_MIN)) begin
      e_sat = CMP_W'(ENERGY_MIN);
    end else begin
      e_sat = e_ext;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    patt_nxt      = patt_r;
    end_nxt       = end_r;
    first_nxt     = first_r;
    go_nxt        = 1'b0;
    n_last_nxt    = n_last_r;
    best_e_nxt    = best_e_r;
    best_p_nxt    = best_p_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.operation == OP_SEARCH)) begin
          if (END_W'(in_data.range_begin) >= end_c) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.min_energy   = '0;
            out_data_nxt.best_pattern = '0;
            out_data_nxt.range_empty  = 1'b1;
          end else begin
            patt_nxt   = END_W'(in_data.range_begin);
            end_nxt    = end_c;
            first_nxt  = 1'b1;
            go_nxt     = 1'b1;
            n_last_nxt = IDX_W'(n_act - 1'b1);
            state_nxt  = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (eu_done) begin
          if (first_r || (eu_energy < best_e_r)) begin
            best_e_nxt = eu_energy;
            best_p_nxt = PATT_W'(patt_r);
          end
          first_nxt = 1'b0;
          if (END_W'(patt_r + 1'b1) == end_r) begin
            state_nxt = ST_REPORT;
          end else begin
            patt_nxt = END_W'(patt_r + 1'b1);
            go_nxt   = 1'b1;
          end
        end
      end
      ST_REPORT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.min_energy   = e_sat[ENERGY_W-1:0];
        out_data_nxt.best_pattern = best_p_r;
        out_data_nxt.range_empty  = 1'b0;
        state_nxt                 = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_bits_r  <= CFG_RESET;
      go_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_bits_r <= cfg_wdata;
      end
    end
    patt_r     <= patt_nxt;
    end_r      <= end_nxt;
    n_last_r   <= n_last_nxt;
    best_e_r   <= best_e_nxt;
    best_p_r   <= best_p_nxt;
    out_data_r <= out_data_nxt;
  end

  qbf_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (WEIGHT_BITS'(in_data.weight)),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  qbf_energy_unit #(
    .MAX_BITS    (MAX_BITS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .ACC_W       (ACC_W),
    .IDX_W       (IDX_W),
    .ADDR_W      (ADDR_W)
  ) u_energy (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .pattern (PATT_W'(patt_r)),
    .n_last  (n_last_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .done    (eu_done),
    .energy  (eu_energy)
  );

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_REPORT ||
                        (accept && in_data.operation == OP_SEARCH)))
    else $error("result strobe without a search ending");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("weight write while searching");

  a_done_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eu_done |-> (state_r == ST_EVAL))
    else $error("energy done outside evaluation");

  a_patt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (patt_r < end_r))
    else $error("pattern counter past range end");

endmodule

// ===== design/qbf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the weight matrix; depends on nothing else.
`timescale 1ns / 1ps

module qbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/qbf_energy_unit.sv =====
// Energy unit: walks all (i, j) pairs of one pattern through the weight RAM
// and accumulates W(i,j) where both bits are set. Depends on qbf_pkg.
`timescale 1ns / 1ps

module qbf_energy_unit #(
  parameter int MAX_BITS    = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int ACC_W       = 25,
  parameter int IDX_W       = 4,
  parameter int ADDR_W      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [qbf_pkg::PATT_W-1:0]    pattern,
  input  logic [IDX_W-1:0]              n_last,
  output logic [ADDR_W-1:0]             rd_addr,
  input  logic [WEIGHT_BITS-1:0]        rd_data,
  output logic                          done,
  output logic signed [ACC_W-1:0]       energy
);

  import qbf_pkg::*;

  localparam int PW = (MAX_BITS > PATT_W) ? MAX_BITS : PATT_W;

  logic              active_r, active_nxt;
  logic              pend_r, pend_nxt;
  logic              take_r, take_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [PW-1:0]     x;

  assign x       = PW'(pattern);
  assign rd_addr = ADDR_W'(ADDR_W'(i_r) * ADDR_W'(MAX_BITS) + ADDR_W'(j_r));
  assign done    = done_r;
  assign energy  = acc_r;

  always_comb begin
    active_nxt = active_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    take_nxt   = 1'b0;
    pend_nxt   = 1'b0;
    last_nxt   = 1'b0;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    if (pend_r && take_r) begin
      acc_nxt = ACC_W'(acc_r + ACC_W'(signed'(rd_data)));
    end
    if (pend_r && last_r) begin
      done_nxt = 1'b1;
    end
    if (go && !active_r) begin
      active_nxt = 1'b1;
      i_nxt      = '0;
      j_nxt      = '0;
      acc_nxt    = '0;
    end else if (active_r) begin
      pend_nxt = 1'b1;
      take_nxt = x[i_r] & x[j_r];
      if (j_r == n_last) begin
        j_nxt = '0;
        if (i_r == n_last) begin
          active_nxt = 1'b0;
          last_nxt   = 1'b1;
        end else begin
          i_nxt = IDX_W'(i_r + 1'b1);
        end
      end else begin
        j_nxt = IDX_W'(j_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      take_r   <= 1'b0;
      last_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      take_r   <= take_nxt;
      last_r   <= last_nxt;
      done_r   <= done_nxt;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench for qubo_brute_force_min_search: queued command driver, result monitor
// and a built-in energy predictor that checks every search result field by field.
// Depends on qbf_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import qbf_pkg::*;

  localparam int unsigned SEARCH_BUDGET = 3000;
  localparam int unsigned LONG_BUDGET   = 20000;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } cmd_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         in_data   = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  cmd_t               cmd_q[$];
  out_item_t          expected_min[$];
  logic signed [15:0] weights [16][16];
  bit                 weight_written [16][16];
  logic [CFG_W-1:0]   n_setting = CFG_RESET;
  int unsigned        gen_bits;
  bit                 took      = 1'b0;
  bit                 gap_done  = 1'b0;
  bit                 idle_now  = 1'b0;
  bit                 quiet     = 1'b0;
  int unsigned        wait_cnt  = 0;
  int unsigned        error_count = 0;

  qubo_brute_force_min_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_n(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return 32'(v);
  endfunction

  function automatic out_item_t search_min(in_item_t c, int unsigned n);
    out_item_t         r;
    longint unsigned   lim;
    longint unsigned   stop;
    longint unsigned   p;
    longint            acc;
    longint            best_e;
    longint unsigned   best_p;
    r = '0;
    lim = 64'd1 << n;
    stop = (c.range_end > lim) ? lim : c.range_end;
    if (c.range_begin >= stop) begin
      r.range_empty = 1'b1;
      return r;
    end
    best_e = 0;
    best_p = 0;
    for (p = c.range_begin; p < stop; p++) begin
      acc = 0;
      for (int i = 0; i < n; i++)
        if (p[i])
          for (int j = 0; j < n; j++)
            if (p[j]) acc += weights[i][j];
      if (p == c.range_begin || acc < best_e) begin
        best_e = acc;
        best_p = p;
      end
    end
    if (best_e > ENERGY_MAX) best_e = ENERGY_MAX;
    if (best_e < ENERGY_MIN) best_e = ENERGY_MIN;
    r.min_energy   = best_e[ENERGY_W-1:0];
    r.best_pattern = best_p[PATT_W-1:0];
    return r;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_min.size() == 0) begin
      $error("unexpected result: min_energy %0d best_pattern %0d range_empty %0d",
             got.min_energy, got.best_pattern, got.range_empty);
      error_count++;
      return;
    end
    want = expected_min.pop_front();
    if (got.min_energy !== want.min_energy) begin
      $error("min_energy expected %0d actual %0d", want.min_energy, got.min_energy);
      error_count++;
    end
    if (got.best_pattern !== want.best_pattern) begin
      $error("best_pattern expected %0d actual %0d", want.best_pattern, got.best_pattern);
      error_count++;
    end
    if (got.range_empty !== want.range_empty) begin
      $error("range_empty expected %0d actual %0d", want.range_empty, got.range_empty);
      error_count++;
    end
  endtask

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (!rst_n) begin
      n_setting = CFG_RESET;
    end else begin
      if (out_valid) check_result(out_data);
      if (cfg_we) n_setting = cfg_wdata;
      if (start && !busy) begin
        if (in_data.operation == OP_LOAD) begin
          weights[in_data.row][in_data.col] = in_data.weight;
        end else begin
          expected_min.push_back(search_min(in_data, active_n(n_setting)));
        end
      end
    end
    idle_now <= rst_n && !start && cmd_q.size() == 0 && expected_min.size() == 0 && !busy;
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      wait_cnt <= 0;
      gap_done <= 1'b0;
    end else if (start && !took) begin
      // hold until transfer
    end else if (wait_cnt != 0) begin
      start    <= 1'b0;
      wait_cnt <= wait_cnt - 1;
    end else if (cmd_q.size() != 0 && cmd_q[0].gap != 0 && !gap_done) begin
      start    <= 1'b0;
      wait_cnt <= cmd_q[0].gap - 1;
      gap_done <= 1'b1;
    end else if (cmd_q.size() != 0) begin
      start    <= 1'b1;
      in_data  <= cmd_q[0].item;
      gap_done <= 1'b0;
      cmd_q.delete(0);
    end else begin
      start <= 1'b0;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (!idle_now);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_bits = active_n(v);
  endtask

  task automatic push_item(in_item_t it);
    cmd_t c;
    c.item = it;
    c.gap  = quiet ? 0 : $urandom_range(0, 8);
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(int unsigned r, int unsigned c, logic signed [15:0] w);
    in_item_t it;
    it.operation   = OP_LOAD;
    it.row         = 4'(r);
    it.col         = 4'(c);
    it.weight      = w;
    it.range_begin = 16'($urandom);
    it.range_end   = 17'($urandom);
    weight_written[r][c] = 1'b1;
    push_item(it);
  endtask

  task automatic push_search(int unsigned b, int unsigned e);
    in_item_t it;
    it.operation   = OP_SEARCH;
    it.row         = 4'($urandom);
    it.col         = 4'($urandom);
    it.weight      = 16'($urandom);
    it.range_begin = 16'(b);
    it.range_end   = 17'(e);
    push_item(it);
  endtask

  task automatic fill_square();
    for (int i = 0; i < gen_bits; i++)
      for (int j = 0; j < gen_bits; j++)
        if (!weight_written[i][j]) push_load(i, j, rand_weight());
  endtask

  task automatic push_random_search();
    int unsigned lim;
    int unsigned span;
    int unsigned len;
    int unsigned b;
    int unsigned e;
    lim  = 1 << gen_bits;
    span = (($urandom_range(0, 7) == 0) ? LONG_BUDGET : SEARCH_BUDGET) /
           (gen_bits * gen_bits + 3);
    if (span == 0) span = 1;
    if (span > lim) span = lim;
    if ($urandom_range(0, 9) == 0) begin
      if (lim <= 65535 && $urandom_range(0, 1)) begin
        b = $urandom_range(lim, 65535);
        e = $urandom_range(0, 17'h1FFFF);
      end else begin
        b = $urandom_range(0, 65535);
        e = $urandom_range(0, b);
      end
    end else begin
      len = $urandom_range(1, span);
      b = ($urandom_range(0, 3) == 0) ? lim - len : $urandom_range(0, lim - len);
      e = b + len;
      if (e == lim && $urandom_range(0, 1)) e = $urandom_range(lim, 17'h1FFFF);
    end
    push_search(b, e);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] setting, int unsigned count, bit hold_midway);
    wait_idle();
    write_cfg(setting);
    quiet = ($urandom_range(0, 3) == 0);
    fill_square();
    for (int k = 0; k < count; k++) begin
      if (hold_midway && k == count / 2) wait_idle();
      if ($urandom_range(0, 9) < 4) begin
        push_load($urandom_range(0, 15), $urandom_range(0, 15), rand_weight());
      end else begin
        push_random_search();
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings[10];
    settings = '{5'd1, 5'd5, 5'd16, 5'd3, 5'd31,
                 5'd8, 5'd17, 5'd12, 5'd6, 5'd2};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    gen_bits = active_n(CFG_RESET);

    // reset setting: empty ranges need no weights
    push_search(0, 0);
    push_search(65535, 0);
    push_load(15, 15, 16'sh8000);

    wait_idle();
    write_cfg(5'd2);
    push_load(0, 0, -16'sd5);
    push_load(1, 1, -16'sd5);
    push_load(0, 1, 16'sd5);
    push_load(1, 0, 16'sd5);
    push_search(0, 4);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        push_load(i, j, 16'sh8000);
    push_search(3, 17'h1FFFF);
    push_search(4, 100);
    push_search(10, 3);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        push_load(i, j, 16'sh7FFF);
    push_search(0, 4);

    wait_idle();
    write_cfg(5'd0);
    push_search(0, 5);
    push_load(0, 0, 16'sh8000);
    push_search(0, 2);
    push_search(1, 1);

    foreach (settings[k]) run_phase(settings[k], 14, k == 0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0 && expected_min.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/qbf_pkg.sv
design/qbf_ram.sv
design/qbf_energy_unit.sv
design/qubo_brute_force_min_search.sv
verif/tb.sv
